@@ design/sfr_pkg.sv @@
// Shared types, constants and the control program of the sensor frame responder.
package sfr_pkg;

    // Channel counts per sample group and the frame length limit.
    localparam int ADC_CHANNELS    = 4;
    localparam int PROX_CHANNELS   = 4;
    localparam int GYRO_CHANNELS   = 3;
    localparam int ACCEL_CHANNELS  = 3;
    localparam int MAX_FRAME_BYTES = 40;

    // Sample store layout.
    localparam int OFS_PROX    = ADC_CHANNELS;
    localparam int OFS_GYRO    = OFS_PROX + PROX_CHANNELS;
    localparam int OFS_ACCEL   = OFS_GYRO + GYRO_CHANNELS;
    localparam int STORE_DEPTH = OFS_ACCEL + ACCEL_CHANNELS;
    localparam int SIDX_W      = $clog2(STORE_DEPTH);

    // Program layout: header and flag bytes, then one step per frame byte.
    localparam int STEP_ADC    = 2;
    localparam int STEP_PROX   = STEP_ADC + 2 * ADC_CHANNELS;
    localparam int STEP_GYRO   = STEP_PROX + 3 * PROX_CHANNELS;
    localparam int STEP_ACCEL  = STEP_GYRO + 3 * GYRO_CHANNELS;
    localparam int UCODE_DEPTH = STEP_ACCEL + 3 * ACCEL_CHANNELS;
    localparam int STEP_W      = $clog2(UCODE_DEPTH + 1);
    localparam int COUNT_W     = $clog2(MAX_FRAME_BYTES + 1);

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;
    localparam int TX_W     = 7;
    localparam int ID_W     = 5;
    localparam int GROUP_W  = 3;
    localparam int CHAN_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_GRPS = 5;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_BUS    = 1'b1;

    // Sample group codes of a sample write.
    localparam logic [GROUP_W-1:0] SG_ADC    = 3'd0;
    localparam logic [GROUP_W-1:0] SG_PROX   = 3'd1;
    localparam logic [GROUP_W-1:0] SG_GYRO   = 3'd2;
    localparam logic [GROUP_W-1:0] SG_ACCEL  = 3'd3;
    localparam logic [GROUP_W-1:0] SG_SWITCH = 3'd4;

    // Command byte decode and the header byte prefix.
    localparam logic [BYTE_W-1:0] CMD_MASK   = 8'hE0;
    localparam logic [BYTE_W-1:0] CMD_ARM    = 8'hA0;
    localparam logic [TX_W-1:0]   HDR_PREFIX = 7'h20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROX_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MASK = 3'd5;

    // Byte source selected by a control word.
    typedef enum logic [2:0] {
        SRC_HDR,
        SRC_FLAG,
        SRC_ADC_HI,
        SRC_ADC_LO,
        SRC_W_HI,
        SRC_W_MID,
        SRC_W_LO
    } src_t;

    // Group a control word belongs to; the fixed group is always enabled.
    typedef enum logic [2:0] {
        GRP_FIX,
        GRP_ADC,
        GRP_PROX,
        GRP_GYRO,
        GRP_ACCEL
    } grp_t;

    // One control word of the program.
    typedef struct packed {
        src_t              src;
        logic [SIDX_W-1:0] sidx;
        grp_t              grp;
        logic              sgn;
        logic              gend;
        logic [STEP_W-1:0] skip;
    } ucode_t;

    typedef ucode_t [UCODE_DEPTH-1:0] ucode_rom_t;

    // Command from the sequencer to the byte formatter.
    typedef struct packed {
        logic              load;
        logic              last;
        src_t              src;
        logic [SIDX_W-1:0] sidx;
        logic              sgn;
    } seq_cmd_t;

    function automatic ucode_rom_t build_ucode();
        ucode_rom_t rom;
        int         s;
        rom = '0;
        s   = 0;
        rom[s].src  = SRC_HDR;
        rom[s].grp  = GRP_FIX;
        s = s + 1;
        rom[s].src  = SRC_FLAG;
        rom[s].grp  = GRP_FIX;
        rom[s].gend = 1'b1;
        s = s + 1;
        for (int c = 0; c < ADC_CHANNELS; c++)
        begin
            rom[s].src  = SRC_ADC_HI;
            rom[s].sidx = SIDX_W'(c);
            rom[s].grp  = GRP_ADC;
            rom[s].skip = STEP_W'(STEP_PROX);
            s = s + 1;
            rom[s].src  = SRC_ADC_LO;
            rom[s].sidx = SIDX_W'(c);
            rom[s].grp  = GRP_ADC;
            rom[s].skip = STEP_W'(STEP_PROX);
            rom[s].gend = (c == ADC_CHANNELS - 1);
            s = s + 1;
        end
        for (int c = 0; c < PROX_CHANNELS + GYRO_CHANNELS + ACCEL_CHANNELS; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rom[s].src  = (k == 0) ? SRC_W_HI : ((k == 1) ? SRC_W_MID : SRC_W_LO);
                rom[s].sidx = SIDX_W'(OFS_PROX + c);
                if (c < PROX_CHANNELS)
                begin
                    rom[s].grp  = GRP_PROX;
                    rom[s].sgn  = 1'b0;
                    rom[s].skip = STEP_W'(STEP_GYRO);
                    rom[s].gend = (c == PROX_CHANNELS - 1) && (k == 2);
                end
                else if (c < PROX_CHANNELS + GYRO_CHANNELS)
                begin
                    rom[s].grp  = GRP_GYRO;
                    rom[s].sgn  = 1'b1;
                    rom[s].skip = STEP_W'(STEP_ACCEL);
                    rom[s].gend = (c == PROX_CHANNELS + GYRO_CHANNELS - 1) && (k == 2);
                end
                else
                begin
                    rom[s].grp  = GRP_ACCEL;
                    rom[s].sgn  = 1'b1;
                    rom[s].skip = STEP_W'(UCODE_DEPTH);
                    rom[s].gend = (c == PROX_CHANNELS + GYRO_CHANNELS + ACCEL_CHANNELS - 1)
                                  && (k == 2);
                end
                s = s + 1;
            end
        end
        return rom;
    endfunction

    localparam ucode_rom_t UCODE = build_ucode();

endpackage

@@ design/sensor_frame_responder.sv @@
// Top level of the sensor frame responder: serial slave that answers requests with sample frames.
//
// Input stream (s_*): each beat is either a sample write (s_tuser = 0) that updates the
// sample store at once, or a received serial byte (s_tuser = 1). A byte 0xA0 | device_id
// arms the block; the next serial byte is the flag byte. If it carries every bit of
// valid_flag_mask it becomes the mode. The flag beat starts a frame on the output stream.
// Output stream (m_*): one 7-bit frame byte per beat in m_tdata[6:0], m_tlast on the final
// byte. The frame is the header 0x20 | device_id, the echoed flag, then the chunks of every
// enabled group (ADC 2 bytes per channel, proximity, gyro, accel 3 bytes per channel).
// After the flag beat is accepted the sequencer enters its run state and then loads the
// header into the output register. The control program steps once per cycle while the
// output register is free and emits one byte per step of an enabled group; a full frame
// is 40 bytes, and a disabled group that lies before a later enabled group is jumped over
// without a byte. The input side holds s_tready low while a frame is being sequenced, so
// one flag byte is handled at a time. A single output register parts the sides: when
// m_tready is low the sequencer pauses on the current step and resumes when the byte is
// taken. Reset clears the sample store, switch level, mode, arming and loads the
// configuration registers with their defaults. The user writes configuration through
// cfg_wr_en, cfg_index and cfg_data only while the block is idle; the block does not enforce this.
module sensor_frame_responder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: bus_byte[7:0], sample_group[10:8], sample_channel[12:11],
    //          sample_value[28:13], zero fill[31:29]
    input  logic [31:0]                       s_tdata,
    // s_tuser: req_type (0 sample write, 1 serial byte)
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: tx_byte[6:0], zero fill[7]
    output logic [7:0]                        m_tdata,
    // m_tlast: last_byte
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0]        cfg_data
);

    // Unpacked input fields.
    logic [sfr_pkg::BYTE_W-1:0]   bus_byte;
    logic [sfr_pkg::GROUP_W-1:0]  sample_group;
    logic [sfr_pkg::CHAN_W-1:0]   sample_channel;
    logic [sfr_pkg::SAMPLE_W-1:0] sample_value;

    assign bus_byte       = s_tdata[7:0];
    assign sample_group   = s_tdata[10:8];
    assign sample_channel = s_tdata[12:11];
    assign sample_value   = s_tdata[28:13];

    // Configuration registers.
    logic [sfr_pkg::ID_W-1:0]   device_id_reg;
    logic [sfr_pkg::BYTE_W-1:0] adc_mask_reg;
    logic [sfr_pkg::BYTE_W-1:0] prox_mask_reg;
    logic [sfr_pkg::BYTE_W-1:0] gyro_mask_reg;
    logic [sfr_pkg::BYTE_W-1:0] accel_mask_reg;
    logic [sfr_pkg::BYTE_W-1:0] valid_mask_reg;

    // Request state.
    logic                       armed_reg;
    logic [sfr_pkg::BYTE_W-1:0] mode_reg;
    logic [sfr_pkg::BYTE_W-1:0] flag_reg;

    logic                         busy;
    logic                         out_free;
    logic                         in_beat;
    logic                         bus_beat;
    logic                         cmd_match;
    logic                         start;
    logic [sfr_pkg::NUM_GRPS-1:0] grp_en;
    sfr_pkg::seq_cmd_t            cmd;
    logic [sfr_pkg::SAMPLE_W-1:0] rd_data;
    logic                         switch_level;

    assign s_tready  = !busy;
    assign in_beat   = s_tvalid && s_tready;
    assign bus_beat  = in_beat && (s_tuser == sfr_pkg::REQ_BUS);
    assign cmd_match = ((bus_byte & sfr_pkg::CMD_MASK) == sfr_pkg::CMD_ARM)
                       && (bus_byte[sfr_pkg::ID_W-1:0] == device_id_reg);
    // Any serial byte taken while armed is the flag byte and starts a frame.
    assign start     = bus_beat && armed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg  <= '0;
            adc_mask_reg   <= 8'h01;
            prox_mask_reg  <= 8'h02;
            gyro_mask_reg  <= 8'h04;
            accel_mask_reg <= 8'h08;
            valid_mask_reg <= 8'h40;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sfr_pkg::CFG_DEVICE_ID:  device_id_reg  <= cfg_data[sfr_pkg::ID_W-1:0];
                sfr_pkg::CFG_ADC_MASK:   adc_mask_reg   <= cfg_data;
                sfr_pkg::CFG_PROX_MASK:  prox_mask_reg  <= cfg_data;
                sfr_pkg::CFG_GYRO_MASK:  gyro_mask_reg  <= cfg_data;
                sfr_pkg::CFG_ACCEL_MASK: accel_mask_reg <= cfg_data;
                sfr_pkg::CFG_VALID_MASK: valid_mask_reg <= cfg_data;
                default:                 device_id_reg  <= device_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            mode_reg  <= '0;
        end
        else if (bus_beat)
        begin
            if (armed_reg)
            begin
                armed_reg <= 1'b0;
                if ((bus_byte & valid_mask_reg) == valid_mask_reg)
                begin
                    mode_reg <= bus_byte;
                end
            end
            else if (cmd_match)
            begin
                armed_reg <= 1'b1;
            end
        end
    end

    // The flag byte is echoed in the frame whether or not it became the mode.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            flag_reg <= bus_byte;
        end
    end

    // A group is on when the mode holds every bit of its mask; a zero mask is always on.
    always_comb
    begin
        grp_en                    = '0;
        grp_en[sfr_pkg::GRP_FIX]   = 1'b1;
        grp_en[sfr_pkg::GRP_ADC]   = ((mode_reg & adc_mask_reg) == adc_mask_reg)
                                     && (sfr_pkg::ADC_CHANNELS != 0);
        grp_en[sfr_pkg::GRP_PROX]  = ((mode_reg & prox_mask_reg) == prox_mask_reg)
                                     && (sfr_pkg::PROX_CHANNELS != 0);
        grp_en[sfr_pkg::GRP_GYRO]  = ((mode_reg & gyro_mask_reg) == gyro_mask_reg)
                                     && (sfr_pkg::GYRO_CHANNELS != 0);
        grp_en[sfr_pkg::GRP_ACCEL] = ((mode_reg & accel_mask_reg) == accel_mask_reg)
                                     && (sfr_pkg::ACCEL_CHANNELS != 0);
    end

    sfr_sample_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (in_beat && (s_tuser == sfr_pkg::REQ_SAMPLE)),
        .wr_group     (sample_group),
        .wr_channel   (sample_channel),
        .wr_value     (sample_value),
        .rd_idx       (cmd.sidx),
        .rd_data      (rd_data),
        .switch_level (switch_level)
    );

    sfr_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .grp_en   (grp_en),
        .out_free (out_free),
        .busy     (busy),
        .cmd      (cmd)
    );

    sfr_formatter u_fmt (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_data      (rd_data),
        .switch_level (switch_level),
        .flag         (flag_reg),
        .device_id    (device_id_reg),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .out_free     (out_free)
    );

endmodule

@@ design/sfr_sample_store.sv @@
// Register store of the latest sensor samples and the switch level.
module sfr_sample_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [sfr_pkg::GROUP_W-1:0]         wr_group,
    input  logic [sfr_pkg::CHAN_W-1:0]          wr_channel,
    input  logic [sfr_pkg::SAMPLE_W-1:0]        wr_value,
    input  logic [sfr_pkg::SIDX_W-1:0]          rd_idx,
    output logic [sfr_pkg::SAMPLE_W-1:0]        rd_data,
    output logic                                switch_level
);

    logic [sfr_pkg::SAMPLE_W-1:0] store_reg [sfr_pkg::STORE_DEPTH];
    logic                         switch_reg;
    logic                         store_hit;
    logic                         switch_hit;
    logic [sfr_pkg::SIDX_W-1:0]   wr_idx;

    // Map a group and channel to a store entry; out-of-range channels are dropped.
    always_comb
    begin
        store_hit  = 1'b0;
        switch_hit = 1'b0;
        wr_idx     = '0;
        unique case (wr_group)
            sfr_pkg::SG_ADC:
            begin
                store_hit = (int'(wr_channel) < sfr_pkg::ADC_CHANNELS);
                wr_idx    = sfr_pkg::SIDX_W'(wr_channel);
            end
            sfr_pkg::SG_PROX:
            begin
                store_hit = (int'(wr_channel) < sfr_pkg::PROX_CHANNELS);
                wr_idx    = sfr_pkg::SIDX_W'(sfr_pkg::OFS_PROX + int'(wr_channel));
            end
            sfr_pkg::SG_GYRO:
            begin
                store_hit = (int'(wr_channel) < sfr_pkg::GYRO_CHANNELS);
                wr_idx    = sfr_pkg::SIDX_W'(sfr_pkg::OFS_GYRO + int'(wr_channel));
            end
            sfr_pkg::SG_ACCEL:
            begin
                store_hit = (int'(wr_channel) < sfr_pkg::ACCEL_CHANNELS);
                wr_idx    = sfr_pkg::SIDX_W'(sfr_pkg::OFS_ACCEL + int'(wr_channel));
            end
            sfr_pkg::SG_SWITCH:
            begin
                switch_hit = 1'b1;
            end
            default:
            begin
                store_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfr_pkg::STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
            switch_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            if (store_hit)
            begin
                store_reg[wr_idx] <= wr_value;
            end
            if (switch_hit)
            begin
                switch_reg <= wr_value[0];
            end
        end
    end

    assign rd_data      = store_reg[rd_idx];
    assign switch_level = switch_reg;

endmodule

@@ design/sfr_sequencer.sv @@
// Microcoded frame sequencer: step counter, control ROM and group skip jumps.
module sfr_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sfr_pkg::NUM_GRPS-1:0]   grp_en,
    input  logic                           out_free,
    output logic                           busy,
    output sfr_pkg::seq_cmd_t              cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                        state_reg;
    logic [sfr_pkg::STEP_W-1:0]    step_reg;
    logic [sfr_pkg::COUNT_W-1:0]   count_reg;
    sfr_pkg::ucode_t               word;
    logic                          grp_on;
    logic                          later_on;
    logic                          is_last;
    logic                          advance;

    assign word   = sfr_pkg::UCODE[step_reg[sfr_pkg::STEP_W-1:0]];
    assign grp_on = grp_en[word.grp];

    // Any group after the current one still enabled?
    always_comb
    begin
        later_on = 1'b0;
        for (int i = 0; i < sfr_pkg::NUM_GRPS; i++)
        begin
            if (i > int'(word.grp))
            begin
                later_on = later_on | grp_en[i];
            end
        end
    end

    assign is_last = (word.gend && !later_on)
                     || (count_reg == sfr_pkg::COUNT_W'(sfr_pkg::MAX_FRAME_BYTES - 1));
    assign advance = (state_reg == S_RUN) && out_free;

    assign cmd.load = advance && grp_on;
    assign cmd.last = is_last;
    assign cmd.src  = word.src;
    assign cmd.sidx = word.sidx;
    assign cmd.sgn  = word.sgn;
    assign busy     = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_RUN;
                        step_reg  <= '0;
                        count_reg <= '0;
                    end
                end
                S_RUN:
                begin
                    if (advance)
                    begin
                        if (grp_on)
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (is_last)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                step_reg <= step_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            step_reg <= word.skip;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_load_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_RUN))
        else $error("byte loaded while sequencer idle");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.last) |=> (state_reg == S_IDLE))
        else $error("sequencer kept running after the last byte");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (count_reg < sfr_pkg::COUNT_W'(sfr_pkg::MAX_FRAME_BYTES)))
        else $error("frame byte count exceeded the limit");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("frame started while a frame is running");
`endif

endmodule

@@ design/sfr_formatter.sv @@
// Builds each 7-bit frame byte from the selected source and holds it in the output register.
module sfr_formatter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sfr_pkg::seq_cmd_t                 cmd,
    input  logic [sfr_pkg::SAMPLE_W-1:0]      rd_data,
    input  logic                              switch_level,
    input  logic [sfr_pkg::BYTE_W-1:0]        flag,
    input  logic [sfr_pkg::ID_W-1:0]          device_id,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [sfr_pkg::BYTE_W-1:0]        m_tdata,
    output logic                              m_tlast,
    output logic                              out_free
);

    logic [sfr_pkg::TX_W-1:0] byte_next;
    logic [sfr_pkg::TX_W-1:0] data_reg;
    logic                     last_reg;
    logic                     valid_reg;
    logic [20:0]              wide;

    // Sample widened to 21 bits, sign-extended for gyro and accel.
    assign wide = {{5{cmd.sgn & rd_data[15]}}, rd_data};

    always_comb
    begin
        unique case (cmd.src)
            sfr_pkg::SRC_HDR:    byte_next = sfr_pkg::HDR_PREFIX
                                             | sfr_pkg::TX_W'(device_id);
            sfr_pkg::SRC_FLAG:   byte_next = flag[sfr_pkg::TX_W-1:0];
            sfr_pkg::SRC_ADC_HI: byte_next = {rd_data[13], rd_data[12] | switch_level,
                                              rd_data[11:7]};
            sfr_pkg::SRC_ADC_LO: byte_next = rd_data[6:0];
            sfr_pkg::SRC_W_HI:   byte_next = wide[20:14];
            sfr_pkg::SRC_W_MID:  byte_next = wide[13:7];
            sfr_pkg::SRC_W_LO:   byte_next = wide[6:0];
            default:             byte_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            data_reg <= byte_next;
            last_reg <= cmd.last;
        end
    end

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, data_reg};
    assign m_tlast  = last_reg;

endmodule
